@@ sv/iee_pkg.sv @@
// Shared types and constants for the infix expression evaluator.
// Used by the front end, the token queue, the back end and the top level.
package iee_pkg;

  // Nesting limit and derived widths
  localparam int MAX_DEPTH = 16;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Token queue between front and back end
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;

  // Characters of the grammar
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TOKEN = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_DEEP  = 2'd3;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_OPEN,
    TK_CLOSE,
    TK_PLUS,
    TK_STAR,
    TK_END,
    TK_OTHER
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  ch;
  } tok_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [7:0]  bad_char;
  } result_t;

endpackage

@@ sv/iee_front.sv @@
// Front end: takes characters off the input stream and classifies them into tokens.
// Depends on iee_pkg; feeds the token queue.
module iee_front (
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,   // [7:0] char_code
  input  logic                      fifo_full_i,
  output logic                      push_o,
  output iee_pkg::tok_t             push_tok_o
);
  import iee_pkg::*;

  tok_kind_e kind;

  always_comb begin
    if (s_axis_tdata_i == CH_END) begin
      kind = TK_END;
    end else if (s_axis_tdata_i >= CH_ZERO && s_axis_tdata_i <= CH_NINE) begin
      kind = TK_DIGIT;
    end else if (s_axis_tdata_i == CH_OPEN) begin
      kind = TK_OPEN;
    end else if (s_axis_tdata_i == CH_CLOSE) begin
      kind = TK_CLOSE;
    end else if (s_axis_tdata_i == CH_PLUS) begin
      kind = TK_PLUS;
    end else if (s_axis_tdata_i == CH_STAR) begin
      kind = TK_STAR;
    end else begin
      kind = TK_OTHER;
    end
  end

  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i;
  assign push_tok_o.kind = kind;
  assign push_tok_o.ch   = s_axis_tdata_i;

endmodule

@@ sv/iee_fifo.sv @@
// Short token queue that decouples the classifier from the evaluator.
// Depends on iee_pkg for the token type and depth.
module iee_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  iee_pkg::tok_t push_tok_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output iee_pkg::tok_t pop_tok_o
);
  import iee_pkg::*;

  tok_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_tok_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_tok_i;
    end
  end

  property p_no_pop_empty;
    @(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty)
    else $error("pop from empty token queue");

  property p_no_push_full;
    @(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o;
  endproperty
  a_no_push_full: assert property (p_no_push_full)
    else $error("push into full token queue");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= FIFO_CNT_W'(FIFO_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("token queue count beyond depth");

endmodule

@@ sv/iee_back.sv @@
// Back end: evaluates tokens, keeps per-level sum and product and the saved-level stack,
// and holds the result in an output register. Depends on iee_pkg.
module iee_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tok_valid_i,
  input  iee_pkg::tok_t          tok_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output iee_pkg::result_t       res_o
);
  import iee_pkg::*;

  logic [31:0]        sum_q, sum_d;
  logic [31:0]        prod_q, prod_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               expect_op_q, expect_op_d;
  logic [1:0]         err_q, err_d;
  logic [7:0]         err_ch_q, err_ch_d;
  logic               close_pend_q, close_pend_d;
  logic [31:0]        inner_q;
  logic [63:0]        rd_q;
  logic [63:0]        stack_mem [MAX_DEPTH];
  logic               res_valid_q, res_valid_d;
  result_t            res_q, res_d;

  logic               out_free;
  logic               is_end;
  logic               stk_wr;
  logic               stk_rd;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DEPTH_W-1:0] depth_m1;
  logic [3:0]         digit;
  logic [31:0]        level_total;

  assign out_free    = !res_valid_q || res_ready_i;
  assign is_end      = (tok_i.kind == TK_END);
  assign pop_o       = tok_valid_i && !close_pend_q && (!is_end || out_free);
  assign depth_m1    = depth_q - 1'b1;
  assign wr_addr     = depth_q[ADDR_W-1:0];
  assign rd_addr     = depth_m1[ADDR_W-1:0];
  assign digit       = 4'(tok_i.ch - CH_ZERO);
  assign level_total = sum_q + prod_q;

  always_comb begin
    sum_d        = sum_q;
    prod_d       = prod_q;
    depth_d      = depth_q;
    expect_op_d  = expect_op_q;
    err_d        = err_q;
    err_ch_d     = err_ch_q;
    close_pend_d = 1'b0;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_d        = res_q;
    stk_wr       = 1'b0;
    stk_rd       = 1'b0;

    if (close_pend_q) begin
      // second half of a close: restore outer level, scale by inner value
      sum_d  = rd_q[63:32];
      prod_d = rd_q[31:0] * inner_q;
    end else if (pop_o) begin
      if (is_end) begin
        res_valid_d = 1'b1;
        res_d.value    = '0;
        res_d.bad_char = '0;
        if (err_q != ST_OK) begin
          res_d.status = err_q;
          if (err_q == ST_TOKEN) begin
            res_d.bad_char = err_ch_q;
          end
        end else if (!expect_op_q || depth_q != '0) begin
          res_d.status = ST_END;
        end else begin
          res_d.status = ST_OK;
          res_d.value  = level_total;
        end
        sum_d       = '0;
        prod_d      = 32'd1;
        depth_d     = '0;
        expect_op_d = 1'b0;
        err_d       = ST_OK;
        err_ch_d    = '0;
      end else if (err_q == ST_OK) begin
        if (!expect_op_q) begin
          case (tok_i.kind)
            TK_DIGIT: begin
              prod_d      = prod_q * {28'd0, digit};
              expect_op_d = 1'b1;
            end
            TK_OPEN: begin
              if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
                err_d = ST_DEEP;
              end else begin
                stk_wr  = 1'b1;
                depth_d = depth_q + 1'b1;
                sum_d   = '0;
                prod_d  = 32'd1;
              end
            end
            default: begin
              err_d    = ST_TOKEN;
              err_ch_d = tok_i.ch;
            end
          endcase
        end else begin
          case (tok_i.kind)
            TK_STAR: begin
              expect_op_d = 1'b0;
            end
            TK_PLUS: begin
              sum_d       = level_total;
              prod_d      = 32'd1;
              expect_op_d = 1'b0;
            end
            TK_CLOSE: begin
              if (depth_q != '0) begin
                stk_rd       = 1'b1;
                depth_d      = depth_m1;
                close_pend_d = 1'b1;
              end else begin
                err_d    = ST_TOKEN;
                err_ch_d = tok_i.ch;
              end
            end
            default: begin
              err_d    = ST_TOKEN;
              err_ch_d = tok_i.ch;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      prod_q       <= 32'd1;
      depth_q      <= '0;
      expect_op_q  <= 1'b0;
      err_q        <= ST_OK;
      err_ch_q     <= '0;
      close_pend_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      sum_q        <= sum_d;
      prod_q       <= prod_d;
      depth_q      <= depth_d;
      expect_op_q  <= expect_op_d;
      err_q        <= err_d;
      err_ch_q     <= err_ch_d;
      close_pend_q <= close_pend_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (stk_wr) begin
      stack_mem[wr_addr] <= {sum_q, prod_q};
    end
    if (stk_rd) begin
      rd_q    <= stack_mem[rd_addr];
      inner_q <= level_total;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  property p_close_holds_queue;
    @(posedge clk_i) disable iff (!rst_ni) close_pend_q |-> !pop_o;
  endproperty
  a_close_holds_queue: assert property (p_close_holds_queue)
    else $error("token consumed during second half of a close");

  property p_close_starts;
    @(posedge clk_i) disable iff (!rst_ni)
      (pop_o && tok_i.kind == TK_CLOSE && err_q == ST_OK && expect_op_q && depth_q != '0)
      |=> close_pend_q && depth_q == $past(depth_q) - 1'b1;
  endproperty
  a_close_starts: assert property (p_close_starts)
    else $error("close did not pop one level");

  property p_depth_bound;
    @(posedge clk_i) disable iff (!rst_ni) depth_q <= DEPTH_W'(MAX_DEPTH);
  endproperty
  a_depth_bound: assert property (p_depth_bound)
    else $error("nesting depth beyond stack size");

  property p_err_value_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && res_q.status != ST_OK) |-> res_q.value == '0;
  endproperty
  a_err_value_zero: assert property (p_err_value_zero)
    else $error("nonzero value reported with an error status");

  property p_bad_char_only_token;
    @(posedge clk_i) disable iff (!rst_ni)
      (res_valid_q && res_q.status != ST_TOKEN) |-> res_q.bad_char == '0;
  endproperty
  a_bad_char_only_token: assert property (p_bad_char_only_token)
    else $error("bad_char set without unexpected-token status");

endmodule

@@ sv/infix_expression_evaluator.sv @@
// Top level of the streaming infix expression evaluator.
// Instantiates iee_front, iee_fifo and iee_back; depends on iee_pkg.
//
// Usage:
//   The slave stream carries one ASCII character per beat; a zero byte ends an
//   expression. Digits, '+', '*' and parentheses are accepted, '*' binding
//   tighter than '+'. For each end marker the master stream delivers exactly
//   one result beat: status, 32-bit wrapped value and offending character.
//   Other characters produce no result beat.
// Throughput: one character per cycle while the token queue has room; a
//   closing parenthesis holds the evaluator through an inner add, then a 32x32
//   multiply with the restored outer product, taking no token meanwhile; the
//   4-entry token queue absorbs short runs; long runs of ')' stall the slave side.
// Result path: an accepted end marker passes through the token queue and the
//   result register before it is presented on the master stream, and waits
//   longer while earlier characters are still queued.
// Reset: clears the queue, the level sum (0), product (1), depth and error
//   state; the saved-level stack needs no clearing.
// Stall: while a result waits on the master side, characters keep being taken
//   and evaluated; only the next end marker waits, and the slave side stalls
//   once the token queue is full.
module infix_expression_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [1:0] status, [33:2] value, [41:34] bad_char
);
  import iee_pkg::*;

  logic    fifo_full;
  logic    fifo_empty;
  logic    push;
  logic    pop;
  tok_t    push_tok;
  tok_t    pop_tok;
  result_t res;

  iee_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .push_tok_o      (push_tok)
  );

  iee_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .full_o     (fifo_full),
    .empty_o    (fifo_empty),
    .pop_i      (pop),
    .pop_tok_o  (pop_tok)
  );

  iee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!fifo_empty),
    .tok_i       (pop_tok),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {6'd0, res.bad_char, res.value, res.status};

endmodule

@@ verif/tb_infix_expression_evaluator.sv @@
// Self-checking testbench for infix_expression_evaluator.
// Streams expressions character by character and checks each result beat
// against a predictor built into the scoreboard. Depends on iee_pkg.
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;
  import iee_pkg::*;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = CH_END;  // [7:0] char_code
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;            // [1:0] status, [33:2] value, [41:34] bad_char

  infix_expression_evaluator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  class expr_scoreboard;
    logic [31:0]        lvl_sum;
    logic [31:0]        lvl_prod;
    logic [63:0]        outer_levels [MAX_DEPTH];
    logic [DEPTH_W-1:0] open_parens;
    bit                 want_op;
    logic [1:0]         err_status;
    logic [7:0]         err_char;
    result_t            results_due [$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear_level();
    endfunction

    function void clear_level();
      lvl_sum     = '0;
      lvl_prod    = 32'd1;
      open_parens = '0;
      want_op     = 1'b0;
      err_status  = ST_OK;
      err_char    = '0;
    endfunction

    function void flag_error(logic [1:0] code, logic [7:0] c);
      if (err_status == ST_OK) begin
        err_status = code;
        err_char   = (code == ST_TOKEN) ? c : 8'd0;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // Advance the predictor by one accepted character; return 1 unless ignored.
    function bit take_char(logic [7:0] c);
      result_t     res;
      logic [31:0] inner;
      logic [63:0] outer;
      if (c == CH_END) begin
        if (err_status == ST_OK && (!want_op || open_parens != 0))
          flag_error(ST_END, 8'd0);
        res.status   = err_status;
        res.value    = (err_status == ST_OK) ? lvl_sum + lvl_prod : 32'd0;
        res.bad_char = (err_status == ST_TOKEN) ? err_char : 8'd0;
        results_due.push_back(res);
        clear_level();
        return 1'b1;
      end
      if (err_status != ST_OK)
        return 1'b0;
      if (!want_op) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          lvl_prod = lvl_prod * 32'(c - CH_ZERO);
          want_op  = 1'b1;
        end else if (c == CH_OPEN) begin
          if (open_parens >= MAX_DEPTH) begin
            flag_error(ST_DEEP, 8'd0);
          end else begin
            outer_levels[open_parens] = {lvl_sum, lvl_prod};
            open_parens = open_parens + 1'b1;
            lvl_sum     = '0;
            lvl_prod    = 32'd1;
          end
        end else begin
          flag_error(ST_TOKEN, c);
        end
      end else begin
        if (c == CH_STAR) begin
          want_op = 1'b0;
        end else if (c == CH_PLUS) begin
          lvl_sum  = lvl_sum + lvl_prod;
          lvl_prod = 32'd1;
          want_op  = 1'b0;
        end else if (c == CH_CLOSE && open_parens != 0) begin
          inner       = lvl_sum + lvl_prod;
          open_parens = open_parens - 1'b1;
          outer       = outer_levels[open_parens];
          lvl_sum     = outer[63:32];
          lvl_prod    = outer[31:0] * inner;
        end else begin
          flag_error(ST_TOKEN, c);
        end
      end
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [47:0] beat);
      result_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", beat));
        return;
      end
      want = results_due.pop_front();
      if (beat[1:0] !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", beat[1:0], want.status));
      if (beat[33:2] !== want.value)
        report_mismatch($sformatf("value %h, expected %h", beat[33:2], want.value));
      if (beat[41:34] !== want.bad_char)
        report_mismatch($sformatf("bad_char %h, expected %h", beat[41:34], want.bad_char));
    endtask
  endclass

  expr_scoreboard sb;
  int  live_count = 0;
  int  burst_left = 0;
  bit  calm       = 1'b0;
  int  rx_mode    = 0;
  int  rx_left    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: hold a stall pattern for a while, then pick another.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(16, 96);
      rx_mode = $urandom_range(0, 3);
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 1) == 0);
      2: m_axis_tready_i <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready_i <= (rx_left < 4);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o);
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    void'(sb.take_char(c));
    live_count++;
  endtask

  task automatic send_seq(ref logic [7:0] s [$]);
    foreach (s[i])
      send_char(s[i]);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++)
      send_char(t[i]);
    send_char(CH_END);
  endtask

  // Hold the sender until every pending result has been delivered.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Build a well-formed expression: lead opening parens, then a random walk.
  function automatic void build_expr(ref logic [7:0] s [$], input int len, input int cap,
                                     input int lead, input int star_pct, input int dig_lo);
    int d;
    int n;
    bit op_next;
    d = 0;
    n = 0;
    op_next = 1'b0;
    repeat (lead) begin
      s.push_back(CH_OPEN);
      d++;
    end
    forever begin
      if (!op_next) begin
        if (n < len && d < cap && $urandom_range(0, 3) == 0) begin
          s.push_back(CH_OPEN);
          d++;
        end else begin
          s.push_back(CH_ZERO + 8'($urandom_range(dig_lo, 9)));
          op_next = 1'b1;
        end
      end else if (n >= len && d == 0) begin
        break;
      end else if (d > 0 && (n >= len || $urandom_range(0, 2) == 0)) begin
        s.push_back(CH_CLOSE);
        d--;
      end else begin
        s.push_back(($urandom_range(0, 99) < star_pct) ? CH_STAR : CH_PLUS);
        op_next = 1'b0;
      end
      n++;
    end
    s.push_back(CH_END);
  endfunction

  function automatic void break_expr(ref logic [7:0] s [$]);
    int k;
    k = $urandom_range(0, s.size() - 2);
    case ($urandom_range(0, 2))
      0: s[k] = 8'($urandom_range(1, 255));
      1: s.insert(k, 8'($urandom_range(1, 255)));
      default: begin
        s = s[0:k];
        s.push_back(CH_END);
      end
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("tb_infix_expression_evaluator NOT OK");
    $finish;
  end

  initial begin
    logic [7:0] expr [$];
    int         pick;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: precedence, digit extremes, parens and the end and token error paths.
    calm = 1'b1;
    send_text("9*8+7");
    send_text("(0)");
    send_text("");
    send_text("+");
    send_text("1+");
    send_text("(2");
    send_text("1)");
    send_text("12");
    send_text("1(");
    send_text("5&x");
    send_char(8'hFF);
    send_char(CH_END);
    drain_results();

    for (int e = 0; live_count < 1400; e++) begin
      expr.delete();
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (e < 2)
        build_expr(expr, $urandom_range(1, 4), MAX_DEPTH, MAX_DEPTH + e, 50, 0);
      else if (pick < 55)
        build_expr(expr, $urandom_range(1, 12), 4, 0, 50, 0);
      else if (pick < 65)
        build_expr(expr, $urandom_range(8, 24), 2, 0, 90, 6);
      else if (pick < 72)
        build_expr(expr, $urandom_range(1, 6), MAX_DEPTH,
                   $urandom_range(MAX_DEPTH - 3, MAX_DEPTH + 1), 50, 0);
      else if (pick < 90) begin
        build_expr(expr, $urandom_range(1, 10), 4, 0, 50, 0);
        break_expr(expr);
      end else begin
        repeat ($urandom_range(1, 8))
          expr.push_back(8'($urandom_range(1, 255)));
        expr.push_back(CH_END);
      end
      send_seq(expr);
      if (e % 40 == 39)
        drain_results();
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("tb_infix_expression_evaluator OK");
    else
      $display("tb_infix_expression_evaluator NOT OK");
    $finish;
  end

endmodule
